@@ rtl/sstq_pkg.sv @@
// ----------------------------------------------------------------------------
// sstq_pkg
// Shared types, codes and compare helpers for the sorted sleep timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sstq_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam logic [31:0] WAKE_NEVER = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_RESUME = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  task_id;
    logic [31:0] delay_ticks;
    logic [7:0]  priority_req;
  } in_t;

  typedef struct packed {
    logic       resumed_valid;
    logic [3:0] resumed_task;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [31:0] wake;
    logic [3:0]  task_id;
    logic [7:0]  prio;
    logic        susp;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_DECIDE,
    ST_SD_RD,
    ST_SD_WR,
    ST_INS_WR,
    ST_SU_RD,
    ST_SU_WR,
    ST_SU_END,
    ST_RES_WR,
    ST_HD_RD,
    ST_HD_CHK,
    ST_DONE
  } state_t;

  function automatic logic diff_pos(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  function automatic logic diff_nonneg(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return !d[31];
  endfunction

endpackage

`default_nettype wire

@@ rtl/sstq_engine.sv @@
// ----------------------------------------------------------------------------
// sstq_engine
// Sequencer over the ordered entry memory: search, shift, insert, rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module sstq_engine
  import sstq_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_busy,
  input  wire in_t  in_data,
  output logic      res_valid,
  input  wire logic res_take,
  output out_t      res
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  entry_t mem [MAX_TASKS];
  entry_t q;

  state_t state, state_next;
  in_t    op;
  logic [CW-1:0] ptr, count, ins_pos;
  logic [AW-1:0] fpos;
  entry_t fent, hd;
  logic found, ins_found, have_stop, rot;
  logic [3:0] stop_id;
  logic [31:0] tick_now, wake_new;

  logic          acc, match, find_stop, head_stop, full, ins_hit;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          we;
  entry_t        wr_data;
  logic [CW:0]   ptr_p2;

  assign acc       = in_valid && !in_busy;
  assign in_busy   = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign wake_new  = tick_now + op.delay_ticks;
  assign match     = (q.task_id == op.task_id);
  assign find_stop = (CW'(ptr + 1'b1) == count) || (match && op.kind != KIND_ADD);
  assign head_stop = (have_stop && q.task_id == stop_id) || !diff_nonneg(tick_now, q.wake);
  assign full      = (count == CW'(MAX_TASKS));
  assign ins_hit   = diff_pos(q.wake, wake_new) ||
                     (q.wake == wake_new && q.prio > op.priority_req);
  assign ptr_p2    = {1'b0, ptr} + (CW+1)'(2);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    q <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (in_data.kind == KIND_TICK) begin
            state_next = (count == '0) ? ST_DONE : ST_HD_RD;
          end else begin
            state_next = (count == '0) ? ST_DECIDE : ST_FIND_RD;
          end
        end
      end
      ST_FIND_RD:  state_next = ST_FIND_CHK;
      ST_FIND_CHK: state_next = find_stop ? ST_DECIDE : ST_FIND_RD;
      ST_DECIDE: begin
        priority case (1'b1)
          op.kind == KIND_ADD && (found || full): state_next = ST_DONE;
          op.kind == KIND_ADD:
            state_next = (ins_pos == count) ? ST_INS_WR : ST_SD_RD;
          !found: state_next = ST_DONE;
          op.kind == KIND_REMOVE:
            state_next = (CW'(fpos) + 1'b1 < count) ? ST_SU_RD : ST_SU_END;
          default: state_next = ST_RES_WR;
        endcase
      end
      ST_SD_RD:  state_next = ST_SD_WR;
      ST_SD_WR:  state_next = (CW'(ptr - 1'b1) > ins_pos) ? ST_SD_RD : ST_INS_WR;
      ST_INS_WR: state_next = ST_DONE;
      ST_SU_RD:  state_next = ST_SU_WR;
      ST_SU_WR:  state_next = (ptr_p2 < {1'b0, count}) ? ST_SU_RD : ST_SU_END;
      ST_SU_END: state_next = rot ? ST_HD_RD : ST_DONE;
      ST_RES_WR: state_next = ST_DONE;
      ST_HD_RD:  state_next = ST_HD_CHK;
      ST_HD_CHK: begin
        if (head_stop) begin
          state_next = ST_DONE;
        end else begin
          state_next = (count > CW'(1)) ? ST_SU_RD : ST_SU_END;
        end
      end
      ST_DONE: state_next = res_take ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = ptr[AW-1:0];
    we      = 1'b0;
    wr_addr = ptr[AW-1:0];
    wr_data = q;
    unique case (state)
      ST_SD_RD:  rd_addr = AW'(ptr - 1'b1);
      ST_SU_RD:  rd_addr = AW'(ptr + 1'b1);
      ST_HD_RD:  rd_addr = '0;
      ST_SD_WR, ST_SU_WR: we = 1'b1;
      ST_INS_WR: begin
        we      = 1'b1;
        wr_addr = ins_pos[AW-1:0];
        wr_data = '{wake: wake_new, task_id: op.task_id, prio: op.priority_req, susp: 1'b1};
      end
      ST_SU_END: begin
        we      = rot;
        wr_addr = AW'(count - 1'b1);
        wr_data = '{wake: WAKE_NEVER, task_id: hd.task_id, prio: hd.prio, susp: 1'b0};
      end
      ST_RES_WR: begin
        we      = 1'b1;
        wr_addr = fpos;
        wr_data = '{wake: fent.wake, task_id: fent.task_id, prio: fent.prio, susp: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      tick_now <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            op        <= in_data;
            ptr       <= '0;
            found     <= 1'b0;
            ins_found <= 1'b0;
            ins_pos   <= count;
            have_stop <= 1'b0;
            rot       <= 1'b0;
            res       <= '0;
            if (in_data.kind == KIND_TICK) begin
              tick_now <= tick_now + 32'd1;
            end
          end
        end
        ST_FIND_CHK: begin
          if (match) begin
            found <= 1'b1;
            fpos  <= ptr[AW-1:0];
            fent  <= q;
          end
          if (!ins_found && ins_hit) begin
            ins_found <= 1'b1;
            ins_pos   <= ptr;
          end
          ptr <= CW'(ptr + 1'b1);
        end
        ST_DECIDE: begin
          priority case (1'b1)
            op.kind == KIND_ADD && found: res.status <= STATUS_MISMATCH;
            op.kind == KIND_ADD && full:  res.status <= STATUS_FULL;
            op.kind == KIND_ADD:          ptr <= count;
            !found:                       res.status <= STATUS_MISMATCH;
            default:                      ptr <= CW'(fpos);
          endcase
        end
        ST_SD_WR:  ptr <= CW'(ptr - 1'b1);
        ST_INS_WR: count <= CW'(count + 1'b1);
        ST_SU_WR:  ptr <= CW'(ptr + 1'b1);
        ST_SU_END: begin
          if (rot) begin
            if (!have_stop) begin
              have_stop <= 1'b1;
              stop_id   <= hd.task_id;
            end
          end else begin
            count <= CW'(count - 1'b1);
          end
        end
        ST_HD_CHK: begin
          if (!head_stop) begin
            hd  <= q;
            rot <= !q.susp;
            ptr <= '0;
            if (q.susp) begin
              res.resumed_valid <= 1'b1;
              res.resumed_task  <= q.task_id;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TASKS))
    else $error("entry count above capacity");

  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    acc && in_data.kind == KIND_TICK |=> tick_now == $past(tick_now) + 32'd1)
    else $error("tick counter did not advance");

  a_resume_on_tick: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.resumed_valid |-> op.kind == KIND_TICK && res.status == STATUS_OK)
    else $error("resume reported outside a tick");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    state == ST_INS_WR |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list");
`endif

endmodule

`default_nettype wire

@@ rtl/sorted_sleep_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_sleep_timer_queue
// Ordered sleep list by wrapping wake tick with priority tiebreak.
// Sequencing: a search reads the list entry by entry and a shift moves
//   entries one by one; an add searches then shifts to open a slot, and a
//   tick takes due heads off the list until one stops the scan.
// Throughput: one word at a time, set by the entry memory sequencer; the
//   next word is taken while a result waits in the output reg.
// Reset: synchronous; list empty and tick counter zero, memory left as is.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_sleep_timer_queue
  import sstq_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic res_valid, res_take;
  out_t res;

  sstq_engine #(.MAX_TASKS(MAX_TASKS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_busy   (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
      out_data  <= res;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_sorted_sleep_timer_queue.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_sleep_timer_queue
// Drives tick, add, remove and resume words through the sleep timer queue
// and checks each result word against an ordered-list predictor kept here,
// or against a fixed expected word for the pinned rows.
`default_nettype none

module tb_sorted_sleep_timer_queue
  import sstq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = MAX_TASKS_DEF;

  typedef struct packed {
    logic [31:0] wake;
    logic [3:0]  id;
    logic [7:0]  prio;
    logic        susp;
  } slot_t;

  typedef struct packed {
    in_t  word;
    logic has_exp;
    out_t exp;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  slot_t      sleepers[$];
  logic [31:0] now_tick;
  out_t       pending_results[$];
  out_t       pinned_results[$];
  logic       pinned_flags[$];
  int         errors;
  int         words_sent;
  int         results_seen;
  int         resumes_seen;
  int         send_idle_pct;
  int         recv_idle_pct;
  row_t       rows[$];

  sorted_sleep_timer_queue dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout at %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int find_sleeper(input logic [3:0] id);
    for (int i = 0; i < sleepers.size(); i++)
      if (sleepers[i].id == id) return i;
    return -1;
  endfunction

  function automatic out_t sleep_queue_step(input in_t w);
    out_t r;
    int pos;
    logic have_stop;
    logic [3:0] stop_id;
    logic [31:0] wk;
    slot_t h;
    slot_t s;
    r = '0;
    if (w.kind == KIND_TICK) begin
      have_stop = 1'b0;
      stop_id = '0;
      now_tick = now_tick + 32'd1;
      while (sleepers.size() > 0 && !(have_stop && sleepers[0].id == stop_id)
             && diff_nonneg(now_tick, sleepers[0].wake)) begin
        h = sleepers.pop_front();
        if (!h.susp) begin
          h.wake = WAKE_NEVER;
          sleepers.push_back(h);
          if (!have_stop) begin
            have_stop = 1'b1;
            stop_id = h.id;
          end
        end else begin
          r.resumed_valid = 1'b1;
          r.resumed_task = h.id;
          break;
        end
      end
    end else if (w.kind == KIND_ADD) begin
      if (find_sleeper(w.task_id) >= 0) r.status = STATUS_MISMATCH;
      else if (sleepers.size() >= DEPTH) r.status = STATUS_FULL;
      else begin
        wk = now_tick + w.delay_ticks;
        for (pos = 0; pos < sleepers.size(); pos++)
          if (diff_pos(sleepers[pos].wake, wk) ||
              (sleepers[pos].wake == wk && sleepers[pos].prio > w.priority_req)) break;
        s.wake = wk;
        s.id = w.task_id;
        s.prio = w.priority_req;
        s.susp = 1'b1;
        sleepers.insert(pos, s);
      end
    end else begin
      pos = find_sleeper(w.task_id);
      if (pos < 0) r.status = STATUS_MISMATCH;
      else if (w.kind == KIND_REMOVE) sleepers.delete(pos);
      else sleepers[pos].susp = 1'b0;
    end
    return r;
  endfunction

  task automatic send_word(input in_t w, input logic has_exp, input out_t exp);
    out_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = sleep_queue_step(w);
    pending_results.push_back(p);
    pinned_results.push_back(exp);
    pinned_flags.push_back(has_exp);
    words_sent++;
  endtask

  always @(posedge clk) begin
    out_t e;
    out_t pe;
    logic pf;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.resumed_valid) resumes_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, out_data);
        end else begin
          e = pending_results.pop_front();
          pe = pinned_results.pop_front();
          pf = pinned_flags.pop_front();
          if (pf) e = pe;
          if (out_data.resumed_valid !== e.resumed_valid) begin
            errors++;
            $display("%0t: resumed_valid expected %0d actual %0d", $time,
                     e.resumed_valid, out_data.resumed_valid);
          end
          if (out_data.resumed_task !== e.resumed_task) begin
            errors++;
            $display("%0t: resumed_task expected %0d actual %0d", $time,
                     e.resumed_task, out_data.resumed_task);
          end
          if (out_data.status !== e.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     out_data.status);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic in_t mk(input logic [1:0] k, input logic [3:0] id,
                             input logic [31:0] t, input logic [7:0] p);
    in_t w;
    w.kind = k;
    w.task_id = id;
    w.delay_ticks = t;
    w.priority_req = p;
    return w;
  endfunction

  function automatic row_t row(input in_t w, input logic he, input logic [1:0] st);
    row_t r;
    r.word = w;
    r.has_exp = he;
    r.exp = '0;
    r.exp.status = st;
    return r;
  endfunction

  function automatic in_t random_word(input int free_pct);
    in_t w;
    int sel;
    w = mk(KIND_TICK, 4'($urandom_range(15)), $urandom, 8'($urandom_range(255)));
    sel = $urandom_range(99);
    if (sel < 40) w.kind = KIND_TICK;
    else if (sel < 70) begin
      w.kind = KIND_ADD;
      case ($urandom_range(3))
        0: w.delay_ticks = $urandom_range(3);
        1: w.delay_ticks = $urandom_range(20);
        2: w.delay_ticks = 32'h7FFF_FFF0 + $urandom_range(31);
        default: w.delay_ticks = $urandom;
      endcase
      if ($urandom_range(1)) w.priority_req = 8'($urandom_range(3));
    end
    else if (sel < 85) w.kind = KIND_RESUME;
    else w.kind = KIND_REMOVE;
    if (free_pct > 0 && $urandom_range(99) < free_pct) w.task_id = 4'($urandom_range(7));
    return w;
  endfunction

  initial begin
    in_t w;
    out_t none;
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    resumes_seen = 0;
    now_tick = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    none = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    rows.push_back(row(mk(KIND_TICK, 4'd0, 32'd0, 8'd0), 1'b1, STATUS_OK));
    rows.push_back(row(mk(KIND_REMOVE, 4'd15, 32'd0, 8'd0), 1'b1, STATUS_MISMATCH));
    rows.push_back(row(mk(KIND_RESUME, 4'd9, 32'd0, 8'd0), 1'b1, STATUS_MISMATCH));
    rows.push_back(row(mk(KIND_ADD, 4'd0, 32'd0, 8'd255), 1'b1, STATUS_OK));
    rows.push_back(row(mk(KIND_ADD, 4'd0, 32'd5, 8'd0), 1'b1, STATUS_MISMATCH));
    for (int i = 1; i < 16; i++)
      rows.push_back(row(mk(KIND_ADD, 4'(i), (i < 8) ? 32'd2 : 32'hFFFF_FFFF,
                            8'(i * 17)), 1'b0, STATUS_OK));
    rows.push_back(row(mk(KIND_ADD, 4'd0, 32'd1, 8'd0), 1'b1, STATUS_MISMATCH));
    rows.push_back(row(mk(KIND_RESUME, 4'd3, 32'd0, 8'd0), 1'b1, STATUS_OK));
    rows.push_back(row(mk(KIND_REMOVE, 4'd15, 32'd0, 8'd0), 1'b1, STATUS_OK));
    rows.push_back(row(mk(KIND_ADD, 4'd15, 32'h8000_0000, 8'd128), 1'b0, STATUS_OK));
    rows.push_back(row(mk(KIND_TICK, 4'd0, 32'd0, 8'd0), 1'b0, STATUS_OK));

    send_idle_pct = 37;
    recv_idle_pct = 84;
    foreach (rows[i]) send_word(rows[i].word, rows[i].has_exp, rows[i].exp);
    repeat (3) send_word(mk(KIND_TICK, 4'd0, 32'd0, 8'd0), 1'b0, none);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 37 : 0;
      for (int n = 0; n < 600; n++) begin
        w = random_word((phase == 2) ? 50 : 0);
        send_word(w, 1'b0, none);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d words, checked %0d results, %0d resumes reported.",
             words_sent, results_seen, resumes_seen);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

`default_nettype wire
